FILE: hdl/bms_pkg.sv
package bms_pkg;

  // Datapath operations, one per controller step
  typedef enum logic [5:0] {
    OP_NOP,
    OP_LOAD,
    OP_SORT,
    OP_PROBE0,
    OP_FLAG,
    OP_UPDATE,
    OP_A1,
    OP_A2,
    OP_A3,
    OP_A4,
    OP_DONE,
    OP_A5,
    OP_A6,
    OP_P1,
    OP_P2,
    OP_P3,
    OP_P4,
    OP_P5,
    OP_P6,
    OP_P7,
    OP_P8,
    OP_P9,
    OP_P10,
    OP_DINIT,
    OP_DSTEP,
    OP_DFIN,
    OP_FIN1,
    OP_FIN2
  } op_e;

  typedef struct packed {
    op_e  op;
    logic en;
  } bms_cmd_t;

  typedef struct packed {
    logic phase_active;
    logic done_hit;
    logic para_ok;
    logic div_ok;
    logic div_last;
  } bms_stat_t;

  localparam logic [1:0] KIND_POINT = 2'd0;
  localparam logic [1:0] KIND_MIN   = 2'd1;
  localparam logic [1:0] KIND_IDLE  = 2'd2;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_ITER  = 2'd2;

  localparam logic REG_ABS_TOL = 1'b0;
  localparam logic REG_REL_TOL = 1'b1;

  localparam int TOL_WIDTH = 16;
  localparam int REL_SHIFT = 16;

  // (3 - sqrt 5)/2 scaled by 2^62
  localparam logic [63:0] GOLD_Q62 = 64'd1761507313596588285;

endpackage

FILE: hdl/bms_ctrl.sv
module bms_ctrl
  import bms_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  logic      req_type_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  bms_stat_t stat_i,
  output bms_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE, S_SORT, S_PROBE0, S_FLAG, S_UPDATE, S_A1, S_A2, S_A3, S_A4, S_CHECK,
    S_DONE, S_A5, S_A6, S_PCHK, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8,
    S_P9, S_P10, S_DCHK, S_DINIT, S_DSTEP, S_DFIN, S_FIN1, S_FIN2
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free, accept, emit;

  assign in_stall_o  = (state_q != S_IDLE);
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.op = OP_NOP;
    cmd_o.en = 1'b1;
    unique case (state_q)
      S_IDLE:   begin cmd_o.op = OP_LOAD; cmd_o.en = accept; end
      S_SORT:   cmd_o.op = OP_SORT;
      S_PROBE0: begin cmd_o.op = OP_PROBE0; cmd_o.en = out_free; end
      S_FLAG:   begin cmd_o.op = OP_FLAG; cmd_o.en = out_free; end
      S_UPDATE: cmd_o.op = OP_UPDATE;
      S_A1:     cmd_o.op = OP_A1;
      S_A2:     cmd_o.op = OP_A2;
      S_A3:     cmd_o.op = OP_A3;
      S_A4:     cmd_o.op = OP_A4;
      S_CHECK:  cmd_o.op = OP_NOP;
      S_DONE:   begin cmd_o.op = OP_DONE; cmd_o.en = out_free; end
      S_A5:     cmd_o.op = OP_A5;
      S_A6:     cmd_o.op = OP_A6;
      S_PCHK:   cmd_o.op = OP_NOP;
      S_P1:     cmd_o.op = OP_P1;
      S_P2:     cmd_o.op = OP_P2;
      S_P3:     cmd_o.op = OP_P3;
      S_P4:     cmd_o.op = OP_P4;
      S_P5:     cmd_o.op = OP_P5;
      S_P6:     cmd_o.op = OP_P6;
      S_P7:     cmd_o.op = OP_P7;
      S_P8:     cmd_o.op = OP_P8;
      S_P9:     cmd_o.op = OP_P9;
      S_P10:    cmd_o.op = OP_P10;
      S_DCHK:   cmd_o.op = OP_NOP;
      S_DINIT:  cmd_o.op = OP_DINIT;
      S_DSTEP:  cmd_o.op = OP_DSTEP;
      S_DFIN:   cmd_o.op = OP_DFIN;
      S_FIN1:   cmd_o.op = OP_FIN1;
      S_FIN2:   begin cmd_o.op = OP_FIN2; cmd_o.en = out_free; end
      default:  cmd_o.en = 1'b0;
    endcase
  end

  assign emit = out_free && (state_q == S_PROBE0 || state_q == S_FLAG ||
                             state_q == S_DONE || state_q == S_FIN2);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!req_type_i) state_d = S_SORT;
          else if (stat_i.phase_active) state_d = S_UPDATE;
          else state_d = S_FLAG;
        end
      end
      S_SORT:   state_d = S_PROBE0;
      S_PROBE0: if (out_free) state_d = S_IDLE;
      S_FLAG:   if (out_free) state_d = S_IDLE;
      S_UPDATE: state_d = S_A1;
      S_A1:     state_d = S_A2;
      S_A2:     state_d = S_A3;
      S_A3:     state_d = S_A4;
      S_A4:     state_d = S_CHECK;
      S_CHECK:  state_d = stat_i.done_hit ? S_DONE : S_A5;
      S_DONE:   if (out_free) state_d = S_IDLE;
      S_A5:     state_d = S_A6;
      S_A6:     state_d = S_PCHK;
      S_PCHK:   state_d = stat_i.para_ok ? S_P1 : S_FIN1;
      S_P1:     state_d = S_P2;
      S_P2:     state_d = S_P3;
      S_P3:     state_d = S_P4;
      S_P4:     state_d = S_P5;
      S_P5:     state_d = S_P6;
      S_P6:     state_d = S_P7;
      S_P7:     state_d = S_P8;
      S_P8:     state_d = S_P9;
      S_P9:     state_d = S_P10;
      S_P10:    state_d = S_DCHK;
      S_DCHK:   state_d = stat_i.div_ok ? S_DINIT : S_FIN1;
      S_DINIT:  state_d = S_DSTEP;
      S_DSTEP:  if (stat_i.div_last) state_d = S_DFIN;
      S_DFIN:   state_d = S_FIN1;
      S_FIN1:   state_d = S_FIN2;
      S_FIN2:   if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (emit) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: hdl/bms_dp.sv
module bms_dp
  import bms_pkg::*;
#(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bms_cmd_t                     cmd_i,
  output bms_stat_t                    stat_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [TOL_WIDTH-1:0]         cfg_wdata_i,
  input  logic signed [WORD_WIDTH-1:0] bound_lo_i,
  input  logic signed [WORD_WIDTH-1:0] bound_hi_i,
  input  logic signed [WORD_WIDTH-1:0] func_value_i,
  output logic [1:0]                   result_kind_o,
  output logic signed [WORD_WIDTH-1:0] point_o,
  output logic signed [WORD_WIDTH-1:0] min_value_o
);

  localparam int W   = WORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int XW  = 2 * W + F;
  localparam int DW  = W + F;
  localparam int CW  = $clog2(DW);
  localparam int GS  = 62 - F;
  localparam logic [63:0] GOLD_R = (GOLD_Q62 + (64'd1 << (GS - 1))) >> GS;
  localparam logic signed [W-1:0] GOLD_W = GOLD_R[W-1:0];
  localparam logic [XW-1:0] LIM = XW'(1) << (W - 1);
  localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  typedef logic signed [W-1:0] word_t;

  function automatic word_t sadd(word_t a, word_t b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return word_t'(s[W-1:0]);
  endfunction

  function automatic word_t ssub(word_t a, word_t b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return word_t'(s[W-1:0]);
  endfunction

  function automatic word_t sabs(word_t a);
    return a[W-1] ? ssub('0, a) : a;
  endfunction

  function automatic logic [W-1:0] mag(word_t a);
    return a[W-1] ? (~a + 1'b1) : a;
  endfunction

  // Apply sign to a magnitude and clamp to the word range
  function automatic word_t sat(logic neg, logic [XW-1:0] m);
    if (neg) begin
      if (m >= LIM) return WMIN;
      return word_t'(~m[W-1:0] + 1'b1);
    end
    if (m >= LIM) return WMAX;
    return word_t'(m[W-1:0]);
  endfunction

  logic [TOL_WIDTH-1:0] abs_tol_q, rel_tol_q;
  word_t range_lo_q, range_hi_q, best_x_q, second_w_q, third_v_q;
  word_t f_best_q, f_second_q, f_third_q, probe_q;
  logic [1:0] phase_q;
  word_t in_lo_q, in_hi_q, in_f_q;
  word_t a_q, b_q, mid_q, half_q, absx_q, tolp_q, tol_q, tol2_q, e_q;
  word_t gop_q, step_q, xw_q, xv_q, t_q, q_q, m1_q, m2_q, p_q, c1_q, c2_q, c3_q;
  logic [DW-1:0] num_q, quo_q;
  logic [W:0]    rem_q;
  logic [CW-1:0] cnt_q;
  logic [1:0]    kind_q;
  word_t         point_q, minv_q;

  // Shared multiplier
  word_t         mx, my;
  logic          m_rel;
  logic [W-1:0]  ma, mb;
  logic          mneg;
  logic [2*W-1:0] mprod, mshift;
  word_t         mul_res;

  always_comb begin
    mx    = GOLD_W;
    my    = gop_q;
    m_rel = 1'b0;
    case (cmd_i.op)
      OP_A2:  begin m_rel = 1'b1; my = absx_q; end
      OP_P1:  begin mx = xw_q; my = ssub(f_best_q, f_third_q); end
      OP_P2:  begin mx = xv_q; my = ssub(f_best_q, f_second_q); end
      OP_P3:  begin mx = xv_q; my = q_q; end
      OP_P4:  begin mx = xw_q; my = t_q; end
      OP_P8:  begin mx = step_q; my = q_q; end
      OP_P9:  begin mx = q_q; my = sadd(ssub(a_q, best_x_q), tol2_q); end
      OP_P10: begin mx = q_q; my = ssub(ssub(b_q, best_x_q), tol2_q); end
      default: ;
    endcase
    ma     = m_rel ? W'(rel_tol_q) : mag(mx);
    mb     = mag(my);
    mneg   = m_rel ? 1'b0 : (mx[W-1] ^ my[W-1]);
    mprod  = (2*W)'(ma) * (2*W)'(mb);
    mshift = m_rel ? (mprod >> REL_SHIFT) : (mprod >> F);
    mul_res = sat(mneg, XW'(mshift));
  end

  // Local combinational helpers
  word_t lo_s, hi_s, x_s;
  logic [W:0] dd, tsum;
  logic [W:0] rem_sh;
  logic       qb;
  word_t      step_adj;

  function automatic logic bound_hi_q_lt();
    return in_hi_q < in_lo_q;
  endfunction

  assign lo_s   = (bound_hi_q_lt()) ? in_hi_q : in_lo_q;
  assign hi_s   = (bound_hi_q_lt()) ? in_lo_q : in_hi_q;
  assign x_s    = best_x_q;
  assign dd     = {b_q[W-1], b_q} - {a_q[W-1], a_q};
  assign tsum   = {1'b0, tolp_q} + (W+1)'(abs_tol_q);
  assign rem_sh = {rem_q[W-1:0], num_q[DW-1]};
  assign qb     = (rem_sh >= {1'b0, q_q});

  always_comb begin
    step_adj = step_q;
    if (sabs(step_q) < tol_q) step_adj = (step_q > 0) ? tol_q : ssub('0, tol_q);
  end

  always_comb begin
    stat_o.phase_active = (phase_q == PH_FIRST) || (phase_q == PH_ITER);
    stat_o.done_hit     = (e_q <= tol2_q);
    stat_o.para_ok      = (sabs(xw_q) >= tol_q);
    stat_o.div_ok       = (sabs(p_q) < sabs(c1_q)) && (p_q > c2_q) && (p_q < c3_q);
    stat_o.div_last     = (cnt_q == CW'(DW - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_tol_q <= TOL_WIDTH'(1);
      rel_tol_q <= TOL_WIDTH'(256);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ABS_TOL: abs_tol_q <= cfg_wdata_i;
        REG_REL_TOL: rel_tol_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_lo_q <= '0;
      range_hi_q <= '0;
      best_x_q   <= '0;
      second_w_q <= '0;
      third_v_q  <= '0;
      f_best_q   <= '0;
      f_second_q <= '0;
      f_third_q  <= '0;
      probe_q    <= '0;
      phase_q    <= PH_IDLE;
    end else if (cmd_i.en) begin
      case (cmd_i.op)
        OP_SORT: begin
          range_lo_q <= lo_s;
          range_hi_q <= hi_s;
        end
        OP_PROBE0: begin
          probe_q <= sadd(range_lo_q, mul_res);
          phase_q <= PH_FIRST;
        end
        OP_UPDATE: begin
          if (phase_q == PH_FIRST) begin
            best_x_q   <= probe_q;
            second_w_q <= probe_q;
            third_v_q  <= probe_q;
            f_best_q   <= in_f_q;
            f_second_q <= in_f_q;
            f_third_q  <= in_f_q;
          end else if (in_f_q <= f_best_q) begin
            if (probe_q < best_x_q) range_hi_q <= best_x_q;
            else range_lo_q <= best_x_q;
            third_v_q  <= second_w_q;
            second_w_q <= best_x_q;
            best_x_q   <= probe_q;
            f_third_q  <= f_second_q;
            f_second_q <= f_best_q;
            f_best_q   <= in_f_q;
          end else begin
            if (probe_q < best_x_q) range_lo_q <= probe_q;
            else range_hi_q <= probe_q;
            if (in_f_q <= f_second_q || second_w_q == best_x_q) begin
              third_v_q  <= second_w_q;
              second_w_q <= probe_q;
              f_third_q  <= f_second_q;
              f_second_q <= in_f_q;
            end else if (in_f_q <= f_third_q || third_v_q == best_x_q ||
                         third_v_q == second_w_q) begin
              third_v_q <= probe_q;
              f_third_q <= in_f_q;
            end
          end
        end
        OP_DONE: phase_q <= PH_IDLE;
        OP_FIN2: begin
          probe_q <= sadd(x_s, step_q);
          phase_q <= PH_ITER;
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      case (cmd_i.op)
        OP_LOAD: begin
          in_lo_q <= bound_lo_i;
          in_hi_q <= bound_hi_i;
          in_f_q  <= func_value_i;
        end
        OP_SORT: gop_q <= ssub(hi_s, lo_s);
        OP_A1: begin
          a_q    <= (range_lo_q < range_hi_q) ? range_lo_q : range_hi_q;
          b_q    <= (range_lo_q < range_hi_q) ? range_hi_q : range_lo_q;
          absx_q <= sabs(x_s);
        end
        OP_A2: begin
          tolp_q <= mul_res;
          half_q <= word_t'(dd[W:1]);
          mid_q  <= word_t'(a_q + word_t'(dd[W:1]));
        end
        OP_A3: tol_q <= (tsum > (W+1)'(WMAX)) ? WMAX : word_t'(tsum[W-1:0]);
        OP_A4: begin
          tol2_q <= sadd(tol_q, tol_q);
          e_q    <= sadd(sabs(ssub(x_s, mid_q)), half_q);
        end
        OP_A5: gop_q <= (x_s < mid_q) ? ssub(b_q, x_s) : ssub(a_q, x_s);
        OP_A6: begin
          step_q <= mul_res;
          xw_q   <= ssub(x_s, second_w_q);
          xv_q   <= ssub(x_s, third_v_q);
        end
        OP_P1: t_q  <= mul_res;
        OP_P2: q_q  <= mul_res;
        OP_P3: m1_q <= mul_res;
        OP_P4: m2_q <= mul_res;
        OP_P5: begin
          p_q <= ssub(m1_q, m2_q);
          q_q <= ssub(q_q, t_q);
        end
        OP_P6: q_q <= sadd(q_q, q_q);
        OP_P7: begin
          if (q_q > 0) p_q <= ssub('0, p_q);
          else q_q <= ssub('0, q_q);
        end
        OP_P8:  c1_q <= mul_res;
        OP_P9:  c2_q <= mul_res;
        OP_P10: c3_q <= mul_res;
        OP_DINIT: begin
          num_q <= DW'(mag(p_q)) << F;
          rem_q <= '0;
          quo_q <= '0;
          cnt_q <= '0;
        end
        OP_DSTEP: begin
          rem_q <= qb ? (rem_sh - {1'b0, q_q}) : rem_sh;
          quo_q <= {quo_q[DW-2:0], qb};
          num_q <= num_q << 1;
          cnt_q <= cnt_q + 1'b1;
        end
        OP_DFIN: step_q <= (q_q <= 0) ? '0 : sat(p_q[W-1], XW'(quo_q));
        OP_FIN1: step_q <= step_adj;
        default: ;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.en) begin
      case (cmd_i.op)
        OP_PROBE0: begin
          kind_q  <= KIND_POINT;
          point_q <= sadd(range_lo_q, mul_res);
          minv_q  <= '0;
        end
        OP_FLAG: begin
          kind_q  <= KIND_IDLE;
          point_q <= '0;
          minv_q  <= '0;
        end
        OP_DONE: begin
          kind_q  <= KIND_MIN;
          point_q <= x_s;
          minv_q  <= f_best_q;
        end
        OP_FIN2: begin
          kind_q  <= KIND_POINT;
          point_q <= sadd(x_s, step_q);
          minv_q  <= '0;
        end
        default: ;
      endcase
    end
  end

  assign result_kind_o = kind_q;
  assign point_o       = point_q;
  assign min_value_o   = minv_q;

endmodule

FILE: hdl/brent_minimizer_step_top.sv
// One-dimensional minimizer (golden section with parabolic interpolation) in saturating
// signed fixed point. The function is evaluated outside: a start transaction (req_type 0)
// brings the bounds and returns the first probe point; each value transaction (req_type 1)
// brings f at the last probe and returns the next probe (result_kind 0) or the minimum
// with its value (result_kind 1). A value with no search running returns result_kind 2.
// A value that ends the search returns the minimum; otherwise a golden step is taken,
// or a parabolic step when interpolation is tried and accepted, in which case a
// bit-serial divider forms a WORD_WIDTH+FRAC_BITS-bit quotient (48 bits at the default
// Q16.16). All products go through the single shared multiplier that executes
// one product per cycle. Input is taken only while the controller is idle; a result
// waits in the output register.
module brent_minimizer_step_top
  import bms_pkg::*;
#(
  parameter int WORD_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [TOL_WIDTH-1:0]         cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         req_type_i,
  input  logic signed [WORD_WIDTH-1:0] bound_lo_i,
  input  logic signed [WORD_WIDTH-1:0] bound_hi_i,
  input  logic signed [WORD_WIDTH-1:0] func_value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   result_kind_o,
  output logic signed [WORD_WIDTH-1:0] point_o,
  output logic signed [WORD_WIDTH-1:0] min_value_o
);

  bms_cmd_t  cmd;
  bms_stat_t stat;

  bms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bms_dp #(
    .WORD_WIDTH (WORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .bound_lo_i    (bound_lo_i),
    .bound_hi_i    (bound_hi_i),
    .func_value_i  (func_value_i),
    .result_kind_o (result_kind_o),
    .point_o       (point_o),
    .min_value_o   (min_value_o)
  );

endmodule
